// ===== hw/rtl/aes256_pkg.sv =====
// aes256_pkg: payload types, sbox tables and round helper functions for the aes-256 core
// used by aes256_ctrl, aes256_dp and aes256_block_cipher; no dependencies
`default_nettype none
package aes256_pkg;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  localparam int unsigned NumRounds   = 14;
  localparam int unsigned NumKeyWords = 60;
  localparam int unsigned NumKeyRegs  = 4;

  localparam logic [1:0] CfgKey0 = 2'd0;
  localparam logic [1:0] CfgKey1 = 2'd1;
  localparam logic [1:0] CfgKey2 = 2'd2;
  localparam logic [1:0] CfgKey3 = 2'd3;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE, CMD_KEY_LOAD, CMD_KEY_STEP, CMD_LOAD, CMD_ROUND, CMD_FINAL
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t     cmd;
    logic [5:0]  kidx;     // key word being generated
    logic [3:0]  round;    // round key index used this cycle
    logic        dec;
  } dp_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // column with row 0 in bits 31:24
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] s0, s1, s2, s3;
    s0 = c[31:24]; s1 = c[23:16]; s2 = c[15:8]; s3 = c[7:0];
    return {xt(s0) ^ xt(s1) ^ s1 ^ s2 ^ s3,
            s0 ^ xt(s1) ^ xt(s2) ^ s2 ^ s3,
            s0 ^ s1 ^ xt(s2) ^ xt(s3) ^ s3,
            xt(s0) ^ s0 ^ s1 ^ s2 ^ xt(s3)};
  endfunction

  // inverse mix as a premultiply by {04,05} followed by the forward mix
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] s0, s1, s2, s3, u, v;
    s0 = c[31:24]; s1 = c[23:16]; s2 = c[15:8]; s3 = c[7:0];
    u = xt(xt(s0 ^ s2));
    v = xt(xt(s1 ^ s3));
    return mix_col({s0 ^ u, s1 ^ v, s2 ^ u, s3 ^ v});
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes256_block_cipher.sv =====
// aes256_block_cipher: top level of the aes-256 ecb core
// depends on aes256_pkg, aes256_ctrl and aes256_dp
`default_nettype none
// AES-256 ECB engine. Load the 256-bit key through cfg_ (indexes 0..3, first key
// byte most significant) while the core is idle; any key write marks the schedule
// stale and it is regenerated one word per cycle before the next item
// is taken. Each item is one 128-bit block plus a mode bit (0 encrypt, 1 decrypt).
// An item passes through the core in order: the initial key add, each of the 14
// rounds through the single shared round unit, and a move of the block
// into the output register, where it sits until taken. The next item is accepted
// right after that move; a result still waiting in the output register holds the
// core only at that last step.
module aes256_block_cipher (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire aes256_pkg::in_item_t   in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output aes256_pkg::out_item_t       out_data,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [63:0]            cfg_wdata
);

  logic [63:0]          key_r [aes256_pkg::NumKeyRegs];
  logic                 out_valid_r, out_valid_nxt;
  logic [127:0]         out_r;
  logic                 out_load;
  logic [127:0]         dp_state;
  aes256_pkg::dp_ctrl_t ctl;

  // key registers, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < aes256_pkg::NumKeyRegs; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes256_pkg::CfgKey0: key_r[0] <= cfg_wdata;
        aes256_pkg::CfgKey1: key_r[1] <= cfg_wdata;
        aes256_pkg::CfgKey2: key_r[2] <= cfg_wdata;
        aes256_pkg::CfgKey3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aes256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .key_dirty (cfg_we),
    .out_free  (!out_valid_r || out_ready),
    .out_load  (out_load),
    .ctl       (ctl)
  );

  aes256_dp u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .key      ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .in_block ({in_data.block_hi, in_data.block_lo}),
    .state    (dp_state)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) out_r <= dp_state;
  end

  assign out_valid          = out_valid_r;
  assign out_data.result_hi = out_r[127:64];
  assign out_data.result_lo = out_r[63:0];

endmodule
`default_nettype wire

// ===== hw/rtl/aes256_ctrl.sv =====
// aes256_ctrl: sequencer for key expansion and round iteration
// depends on aes256_pkg
`default_nettype none
module aes256_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_mode,
  input  wire logic                key_dirty,   // key register written this cycle
  input  wire logic                out_free,    // output register empty or draining
  output logic                     out_load,
  output aes256_pkg::dp_ctrl_t     ctl
);

  typedef enum logic [1:0] {S_IDLE, S_KEY, S_RUN, S_DONE} state_t;

  state_t     state_r, state_nxt;
  logic       ready_keys_r, ready_keys_nxt;
  logic [5:0] kidx_r, kidx_nxt;
  logic [3:0] step_r, step_nxt;
  logic       dec_r, dec_nxt;

  assign in_ready = (state_r == S_IDLE) && ready_keys_r && !key_dirty;

  always_comb begin
    state_nxt      = state_r;
    ready_keys_nxt = ready_keys_r;
    kidx_nxt       = kidx_r;
    step_nxt       = step_r;
    dec_nxt        = dec_r;
    out_load       = 1'b0;
    ctl.cmd        = aes256_pkg::CMD_NONE;
    ctl.kidx       = kidx_r;
    ctl.dec        = dec_r;
    ctl.round      = dec_r ? 4'(aes256_pkg::NumRounds) - step_r : step_r;
    unique case (state_r)
      S_IDLE: begin
        if (key_dirty) begin
          ready_keys_nxt = 1'b0;
        end else if (!ready_keys_r) begin
          ctl.cmd   = aes256_pkg::CMD_KEY_LOAD;
          kidx_nxt  = 6'd8;
          state_nxt = S_KEY;
        end else if (in_valid) begin
          dec_nxt   = in_mode;
          ctl.dec   = in_mode;
          ctl.round = in_mode ? 4'(aes256_pkg::NumRounds) : 4'd0;
          ctl.cmd   = aes256_pkg::CMD_LOAD;
          step_nxt  = 4'd1;
          state_nxt = S_RUN;
        end
      end
      S_KEY: begin
        ctl.cmd  = aes256_pkg::CMD_KEY_STEP;
        kidx_nxt = kidx_r + 6'd1;
        if (key_dirty) begin
          // key changed under the expansion, start over from idle
          state_nxt = S_IDLE;
        end else if (kidx_r == 6'(aes256_pkg::NumKeyWords - 1)) begin
          ready_keys_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RUN: begin
        if (step_r == 4'(aes256_pkg::NumRounds)) begin
          ctl.cmd   = aes256_pkg::CMD_FINAL;
          state_nxt = S_DONE;
        end else begin
          ctl.cmd  = aes256_pkg::CMD_ROUND;
          step_nxt = step_r + 4'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // any key write makes the schedule stale
    if (key_dirty) ready_keys_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ready_keys_r <= 1'b0;
      kidx_r       <= '0;
      step_r       <= '0;
      dec_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ready_keys_r <= ready_keys_nxt;
      kidx_r       <= kidx_nxt;
      step_r       <= step_nxt;
      dec_r        <= dec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aes256_dp.sv =====
// aes256_dp: round-key memory, key expansion step and shared round unit
// depends on aes256_pkg
`default_nettype none
module aes256_dp (
  input  wire logic                  clk,
  input  wire aes256_pkg::dp_ctrl_t  ctl,
  input  wire logic [255:0]          key,
  input  wire logic [127:0]          in_block,
  output logic [127:0]               state
);

  // eight-word window of the schedule, rk memory holds all 60 words
  logic [31:0]  win_r [8];
  logic [31:0]  win_nxt [8];
  logic [127:0] rk_mem [15];
  logic [127:0] state_r, state_nxt;
  logic [127:0] rk;
  logic [31:0]  t, neww;
  logic [7:0]   rc;
  logic [127:0] sb, sr, mx, x;

  assign state = state_r;
  assign rk    = rk_mem[ctl.round];

  always_comb begin
    t = win_r[7];
    unique case (ctl.kidx[5:3])
      3'd1: rc = 8'h01;
      3'd2: rc = 8'h02;
      3'd3: rc = 8'h04;
      3'd4: rc = 8'h08;
      3'd5: rc = 8'h10;
      3'd6: rc = 8'h20;
      3'd7: rc = 8'h40;
      default: rc = 8'h00;
    endcase
    if (ctl.kidx[2:0] == 3'd0) begin
      t = aes256_pkg::sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
    end else if (ctl.kidx[2:0] == 3'd4) begin
      t = aes256_pkg::sbox_word(t);
    end
    neww = win_r[0] ^ t;
    for (int i = 0; i < 7; i++) win_nxt[i] = win_r[i + 1];
    win_nxt[7] = neww;
  end

  // round transform; column c in bits 127-32c, row 0 most significant
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127 - 8*i -: 8] = ctl.dec ? aes256_pkg::inv_sbox(state_r[127 - 8*i -: 8])
                                   : aes256_pkg::sbox(state_r[127 - 8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 32*c - 8*r -: 8] = ctl.dec ? sb[127 - 32*((c + 4 - r) % 4) - 8*r -: 8]
                                            : sb[127 - 32*((c + r) % 4) - 8*r -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      // decrypt mixes after the key add, so mix (sr ^ rk)
      mx[127 - 32*c -: 32] = ctl.dec
        ? aes256_pkg::inv_mix_col(sr[127 - 32*c -: 32] ^ rk[127 - 32*c -: 32])
        : aes256_pkg::mix_col(sr[127 - 32*c -: 32]) ^ rk[127 - 32*c -: 32];
    end
    x = sr ^ rk;
    unique case (ctl.cmd)
      aes256_pkg::CMD_LOAD:  state_nxt = in_block ^ rk;
      aes256_pkg::CMD_ROUND: state_nxt = mx;
      aes256_pkg::CMD_FINAL: state_nxt = x;
      default:               state_nxt = state_r;
    endcase
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    if (ctl.cmd == aes256_pkg::CMD_KEY_LOAD) begin
      for (int i = 0; i < 8; i++) win_r[i] <= key[255 - 32*i -: 32];
      rk_mem[0] <= key[255:128];
      rk_mem[1] <= key[127:0];
    end else if (ctl.cmd == aes256_pkg::CMD_KEY_STEP) begin
      for (int i = 0; i < 8; i++) win_r[i] <= win_nxt[i];
      if (ctl.kidx[1:0] == 2'd3) begin
        rk_mem[ctl.kidx[5:2]] <= {win_r[5], win_r[6], win_r[7], neww};
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/aes256_block_cipher_checker.sv =====
// aes256_block_cipher_checker: watches the item channels of the aes-256 core, predicts
// each result block from its own key schedule and compares; depends on aes256_pkg
`default_nettype none
module aes256_block_cipher_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire aes256_pkg::in_item_t in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire aes256_pkg::out_item_t out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_wdata,
  output int                        fail_count,
  output int                        pending_blocks
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] key_regs [aes256_pkg::NumKeyRegs];
  logic [31:0] sched [aes256_pkg::NumKeyWords];
  bit          sched_valid;
  aes256_pkg::out_item_t expected_blocks [$];

  function automatic logic [7:0] fwd_sub(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return tab[a];
  endfunction

  // inverse found by search over the forward table
  function automatic logic [7:0] bwd_sub(input logic [7:0] a);
    for (int i = 0; i < 256; i++)
      if (fwd_sub(8'(i)) == a) return 8'(i);
    return 8'h00;
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub_all_bytes(input logic [31:0] w);
    return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
  endfunction

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      sched[2*i]   = key_regs[i][63:32];
      sched[2*i+1] = key_regs[i][31:0];
    end
    for (int i = 8; i < aes256_pkg::NumKeyWords; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = sub_all_bytes({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0};
      end else if (i % 8 == 4) begin
        t = sub_all_bytes(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
    sched_valid = 1;
  endtask

  // state bytes st[4*c+r]: row r, column c
  function automatic aes256_pkg::out_item_t cipher_block(input aes256_pkg::in_item_t it);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] col [4];
    logic [7:0] fm [4];
    logic [7:0] im [4];
    aes256_pkg::out_item_t res;
    int         nr;
    int         rnd;
    bit         dec;
    nr = int'(aes256_pkg::NumRounds);
    fm = '{8'd2, 8'd3, 8'd1, 8'd1};
    im = '{8'd14, 8'd11, 8'd13, 8'd9};
    dec = it.mode;
    for (int i = 0; i < 8; i++) begin
      st[i]   = it.block_hi[63-8*i -: 8];
      st[i+8] = it.block_lo[63-8*i -: 8];
    end
    for (int step = 0; step <= nr; step++) begin
      rnd = dec ? nr - step : step;
      if (step > 0) begin
        tmp = st;
        for (int r = 1; r < 4; r++)
          for (int c = 0; c < 4; c++)
            if (dec) st[4*((c+r)%4)+r] = tmp[4*c+r];
            else st[4*c+r] = tmp[4*((c+r)%4)+r];
        for (int i = 0; i < 16; i++) st[i] = dec ? bwd_sub(st[i]) : fwd_sub(st[i]);
        // forward mixes before the key add, inverse after it
        if (!dec && step < nr) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
            for (int r = 0; r < 4; r++) begin
              st[4*c+r] = '0;
              for (int j = 0; j < 4; j++) st[4*c+r] ^= gmul(col[j], fm[(j+4-r)%4]);
            end
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          st[4*c+r] ^= sched[rnd*4+c][31-8*r -: 8];
      if (dec && step > 0 && step < nr) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) col[r] = st[4*c+r];
          for (int r = 0; r < 4; r++) begin
            st[4*c+r] = '0;
            for (int j = 0; j < 4; j++) st[4*c+r] ^= gmul(col[j], im[(j+4-r)%4]);
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63-8*i -: 8] = st[i];
      res.result_lo[63-8*i -: 8] = st[i+8];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    aes256_pkg::out_item_t want;
    if (!rst_n) begin
      foreach (key_regs[i]) key_regs[i] = '0;
      sched_valid = 0;
      expected_blocks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        key_regs[cfg_index] = cfg_wdata;
        sched_valid = 0;
      end
      if (in_valid && in_ready) begin
        if (!sched_valid) expand_schedule();
        expected_blocks = {expected_blocks, cipher_block(in_data)};
      end
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_data.result_hi !== want.result_hi) begin
            $display("%0t: result_hi expected %h actual %h", $time, want.result_hi,
                     out_data.result_hi);
            fail_count++;
          end
          if (out_data.result_lo !== want.result_lo) begin
            $display("%0t: result_lo expected %h actual %h", $time, want.result_lo,
                     out_data.result_lo);
            fail_count++;
          end
        end
      end
    end
    pending_blocks = expected_blocks.size();
  end
endmodule
`default_nettype wire

// ===== verif/aes256_block_cipher_tb.sv =====
// aes256_block_cipher_tb: stimulus and verdict for the aes-256 ecb core
// depends on aes256_pkg, aes256_block_cipher and aes256_block_cipher_checker
`default_nettype none
module aes256_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  aes256_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  aes256_pkg::out_item_t out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = aes256_pkg::CfgKey0;
  logic [63:0] cfg_wdata = '0;
  int        fail_count;
  int        pending_blocks;

  // receiver controls
  bit rx_idle_bursts = 1;
  bit rx_hold = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  aes256_block_cipher dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  aes256_block_cipher_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending_blocks
  );

  // receiver: random stall bursts, or a long hold counted here
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end else if (rx_idle_bursts && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_ready <= 0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one item, with optional idle burst in front
  task automatic send_block(input logic m, input logic [63:0] hi, input logic [63:0] lo,
                            input bit gaps);
    aes256_pkg::in_item_t it;
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    it.mode = m;
    it.block_hi = hi;
    it.block_lo = lo;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    // let the checker count the last accepted item before pending_blocks is read
    @(posedge clk);
    while (pending_blocks != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    logic [63:0] kw [4];
    kw = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= 2'(i);
      cfg_wdata <= kw[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] h, l;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset key (all zero), extremes, both modes
    send_block(0, '0, '0, 0);
    send_block(1, '0, '0, 0);
    send_block(0, '1, '1, 0);
    send_block(1, '1, '1, 0);
    drain();
    // standard test key with the standard plaintext
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 0);
    send_block(0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
    send_block(1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0);
    drain();
    load_key('1, '1, '1, '1);
    send_block(0, 64'h8000000000000000, 64'h1, 0);
    send_block(1, 64'h1, 64'h8000000000000000, 0);
    drain();
    // a single key word rewrite makes the schedule stale again
    cfg_we <= 1;
    cfg_index <= aes256_pkg::CfgKey2;
    cfg_wdata <= 64'h0123456789abcdef;
    @(posedge clk);
    cfg_we <= 0;
    send_block(0, '1, '0, 0);
    send_block(1, '0, '1, 0);

    // long receiver hold while the sender keeps offering items
    rx_hold = 1;
    for (int i = 0; i < 8; i++) send_block(i[0], rand64(), rand64(), 0);
    // sender pause until everything is back, then random phases with new keys
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < 100; i++) begin
        h = rand64();
        l = rand64();
        // occasionally sparse or saturated blocks
        case ($urandom_range(0, 9))
          0: h = '0;
          1: l = '1;
          default: ;
        endcase
        send_block(1'($urandom_range(0, 1)), h, l, 1);
      end
      drain();
    end

    // final part without idling on either side
    rx_idle_bursts = 0;
    load_key('0, '1, '0, '1);
    for (int i = 0; i < 30; i++) send_block(1'($urandom_range(0, 1)), rand64(), rand64(), 0);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
